// File: hw/rtl/lrwpp_pkg.sv
package lrwpp_pkg;

  localparam int unsigned PARTICLE_COUNT = 1024;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned DRAW_W  = 14;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned POS_W   = 16;

  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7fff;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

  localparam logic CMD_EMIT  = 1'b0;
  localparam logic CMD_VISIT = 1'b1;

  localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd3;
  localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd5;
  localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd6;
  localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd7;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DIED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                    live;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } particle_t;

  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } stack_ctl_t;

endpackage

// File: hw/rtl/lrwpp_part_mem.sv
module lrwpp_part_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [lrwpp_pkg::SLOT_W-1:0]    waddr,
  input  lrwpp_pkg::particle_t            wdata,
  input  logic                            re,
  input  logic [lrwpp_pkg::SLOT_W-1:0]    raddr,
  output lrwpp_pkg::particle_t            rdata
);

  lrwpp_pkg::particle_t mem [lrwpp_pkg::PARTICLE_COUNT];
  lrwpp_pkg::particle_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/lrwpp_free_stack.sv
module lrwpp_free_stack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lrwpp_pkg::stack_ctl_t         ctl,
  input  logic [lrwpp_pkg::SLOT_W-1:0]  push_slot,
  output logic [lrwpp_pkg::SLOT_W-1:0]  top_slot,
  output logic                          empty
);

  localparam logic [lrwpp_pkg::COUNT_W-1:0] SLOT_COUNT =
    lrwpp_pkg::COUNT_W'(lrwpp_pkg::PARTICLE_COUNT);

  logic [lrwpp_pkg::SLOT_W-1:0]  mem [lrwpp_pkg::PARTICLE_COUNT];
  logic [lrwpp_pkg::COUNT_W-1:0] count_r;
  logic [lrwpp_pkg::COUNT_W-1:0] low_r;
  logic [lrwpp_pkg::COUNT_W-1:0] count_dec;
  logic [lrwpp_pkg::SLOT_W-1:0]  rd_data_r;
  logic [lrwpp_pkg::SLOT_W-1:0]  dflt_slot_r;
  logic                          dflt_r;
  logic                          can_push;

  assign count_dec = count_r - 1'b1;
  assign can_push  = count_r < SLOT_COUNT;

  // entries below the low-water mark were never written; a read there returns the entry's own index instead
  always_ff @(posedge clk) begin
    if (ctl.push && can_push) begin
      mem[count_r[lrwpp_pkg::SLOT_W-1:0]] <= push_slot;
    end
    if (ctl.rd) begin
      rd_data_r   <= mem[count_dec[lrwpp_pkg::SLOT_W-1:0]];
      dflt_r      <= count_dec < low_r;
      dflt_slot_r <= count_dec[lrwpp_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SLOT_COUNT;
      low_r   <= SLOT_COUNT;
    end else if (ctl.pop) begin
      count_r <= count_dec;
      if (count_dec < low_r) begin
        low_r <= count_dec;
      end
    end else if (ctl.push && can_push) begin
      count_r <= count_r + 1'b1;
    end
  end

  assign top_slot = dflt_r ? dflt_slot_r : rd_data_r;
  assign empty    = count_r == '0;

endmodule

// File: hw/rtl/lattice_random_walk_particle_pool_unit.sv
// The input beat is taken in ST_IDLE; the result is registered from ST_EXEC once the output register is free.
// Each item takes a slot memory read, then modify and write back; no new input beat is taken meanwhile.
// A waiting result does not block the next input beat unless a second result is ready.
// Reset: synchronous, active low; then a pass through ST_CLEAR clears every slot of the slot memory,
// with in_tready low throughout.
module lattice_random_walk_particle_pool_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // slot, death_draw, death_threshold, dir_draw
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // slot_out, alive, pos_x, pos_y, pos_z
  output logic [1:0]  out_tuser   // status
);

  localparam int unsigned SW = lrwpp_pkg::SLOT_W;
  localparam int unsigned DW = lrwpp_pkg::DRAW_W;
  localparam int unsigned PW = lrwpp_pkg::POS_W;

  lrwpp_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic                          cmd_r;
  logic [SW-1:0]                 slot_r;
  logic [DW-1:0]                 ddraw_r;
  logic [DW-1:0]                 dthr_r;
  logic [lrwpp_pkg::DIR_W-1:0]   dir_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [63:0]                   out_data_r;
  lrwpp_pkg::status_t            out_status_r;

  logic                          accept;
  logic                          commit;

  lrwpp_pkg::particle_t          pm_rdata, pm_wdata, moved;
  logic                          pm_we;
  logic [SW-1:0]                 pm_waddr;
  lrwpp_pkg::stack_ctl_t         stk_ctl;
  logic [SW-1:0]                 stk_top;
  logic                          stk_empty;

  logic [SW-1:0]                 res_slot;
  logic                          res_alive;
  logic signed [PW-1:0]          res_x, res_y, res_z;
  lrwpp_pkg::status_t            res_status;

  assign accept = in_tvalid && in_tready;

  lrwpp_part_mem u_part_mem (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .re    (accept),
    .raddr (in_tdata[SW-1:0]),
    .rdata (pm_rdata)
  );

  lrwpp_free_stack u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .push_slot (slot_r),
    .top_slot  (stk_top),
    .empty     (stk_empty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrwpp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_tuser;
      slot_r  <= in_tdata[SW-1:0];
      ddraw_r <= in_tdata[SW+DW-1:SW];
      dthr_r  <= in_tdata[SW+2*DW-1:SW+DW];
      dir_r   <= in_tdata[SW+2*DW+lrwpp_pkg::DIR_W-1:SW+2*DW];
    end
    if (commit) begin
      out_data_r   <= {5'd0, res_z, res_y, res_x, res_alive, res_slot};
      out_status_r <= res_status;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      lrwpp_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {SW{1'b1}}) begin
          state_nxt = lrwpp_pkg::ST_IDLE;
        end
      end
      lrwpp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = lrwpp_pkg::ST_EXEC;
        end
      end
      lrwpp_pkg::ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = lrwpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lrwpp_pkg::ST_CLEAR;
    endcase
  end

  // single lattice step with saturation
  always_comb begin
    moved = pm_rdata;
    unique case (dir_r)
      lrwpp_pkg::DIR_NEG_X: if (pm_rdata.x != lrwpp_pkg::POS_MIN) moved.x = pm_rdata.x - 1'b1;
      lrwpp_pkg::DIR_POS_Y: if (pm_rdata.y != lrwpp_pkg::POS_MAX) moved.y = pm_rdata.y + 1'b1;
      lrwpp_pkg::DIR_NEG_Y: if (pm_rdata.y != lrwpp_pkg::POS_MIN) moved.y = pm_rdata.y - 1'b1;
      lrwpp_pkg::DIR_POS_Z: if (pm_rdata.z != lrwpp_pkg::POS_MAX) moved.z = pm_rdata.z + 1'b1;
      lrwpp_pkg::DIR_NEG_Z: if (pm_rdata.z != lrwpp_pkg::POS_MIN) moved.z = pm_rdata.z - 1'b1;
      default:              if (pm_rdata.x != lrwpp_pkg::POS_MAX) moved.x = pm_rdata.x + 1'b1;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    commit        = 1'b0;
    pm_we         = 1'b0;
    pm_waddr      = slot_r;
    pm_wdata      = moved;
    stk_ctl       = '0;
    res_slot      = slot_r;
    res_alive     = 1'b0;
    res_x         = '0;
    res_y         = '0;
    res_z         = '0;
    res_status    = lrwpp_pkg::STATUS_OK;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      lrwpp_pkg::ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_cnt_r;
        pm_wdata = '0;
      end
      lrwpp_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        stk_ctl.rd = in_tvalid && (in_tuser == lrwpp_pkg::CMD_EMIT);
      end
      lrwpp_pkg::ST_EXEC: begin
        commit = !out_valid_r || out_tready;
        if (commit) begin
          out_valid_nxt = 1'b1;
        end
        if (cmd_r == lrwpp_pkg::CMD_EMIT) begin
          if (stk_empty) begin
            res_slot   = '0;
            res_status = lrwpp_pkg::STATUS_FULL;
          end else begin
            res_slot      = stk_top;
            res_alive     = 1'b1;
            pm_we         = commit;
            pm_waddr      = stk_top;
            pm_wdata      = '0;
            pm_wdata.live = 1'b1;
            stk_ctl.pop   = commit;
          end
        end else if (pm_rdata.live) begin
          if (ddraw_r < dthr_r) begin
            res_status    = lrwpp_pkg::STATUS_DIED;
            pm_we         = commit;
            pm_wdata      = pm_rdata;
            pm_wdata.live = 1'b0;
            stk_ctl.push  = commit;
          end else begin
            res_alive = 1'b1;
            res_x     = moved.x;
            res_y     = moved.y;
            res_z     = moved.z;
            pm_we     = commit;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
